>>> rtl/nhp_pkg.sv
// Shared types and constants for the network header parser.
package nhp_pkg;

   localparam int POSITION_BITS = 10;
   localparam int LEN_W         = POSITION_BITS + 1;
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   // Header byte positions
   localparam logic [POSITION_BITS-1:0] POS_FC     = POSITION_BITS'(0);
   localparam logic [POSITION_BITS-1:0] POS_SEQ    = POSITION_BITS'(1);
   localparam logic [POSITION_BITS-1:0] POS_DST_LO = POSITION_BITS'(2);
   localparam logic [POSITION_BITS-1:0] POS_DST_HI = POSITION_BITS'(3);
   localparam logic [POSITION_BITS-1:0] POS_SRC_LO = POSITION_BITS'(4);
   localparam logic [POSITION_BITS-1:0] POS_SRC_HI = POSITION_BITS'(5);
   localparam logic [POSITION_BITS-1:0] POS_RADIUS = POSITION_BITS'(6);
   localparam logic [POSITION_BITS-1:0] POS_MARKER = POSITION_BITS'(7);
   localparam logic [POSITION_BITS-1:0] POS_COUNT  = POSITION_BITS'(8);

   localparam int       FC_SECURITY_BIT = 0;
   localparam int       FC_ROUTE_BIT    = 3;
   localparam logic [7:0] ROUTE_MARKER  = 8'h04;
   localparam logic [LEN_W-1:0] BASE_HDR_LEN = LEN_W'(7);
   localparam logic [LEN_W-1:0] EXT_HDR_BASE = LEN_W'(9);

   localparam logic KIND_HOP = 1'b0;
   localparam logic KIND_END = 1'b1;

   localparam int FIFO_DEPTH = 2;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_frame;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] hop_address;
      logic        ok;
      logic        security;
      logic        source_route;
      logic [7:0]  sequence_res;
      logic [15:0] destination;
      logic [15:0] source;
      logic [7:0]  radius;
      logic [9:0]  header_length;
      logic [7:0]  route_count;
      logic        last_result;
   } rsp_type;

   // Results caused by one input byte: an optional hop, then an optional frame end
   typedef struct packed {
      logic    hop_vld;
      logic    end_vld;
      rsp_type hop_rsp;
      rsp_type end_rsp;
   } entry_type;

endpackage

>>> rtl/network_header_parser_unit.sv
// Network header parser with source-route extension: top level.
//
// Takes one frame byte per cycle while req_stall is low and parses the network
// header on the fly. Each byte is captured straight into the header field
// registers; a completed hop address and the frame-end summary are queued in a
// two-entry result queue. With the result side free-flowing, one byte is
// accepted every cycle; a byte that both completes a hop and ends the frame
// yields two results from one queue entry, and the queue soaks up the extra.
// The result port delivers one transfer per cycle while rsp_stall is low, so
// req_stall rises only when the queue is full and its head is not leaving.
// Results are registered in the queue before they reach the result port.
module network_header_parser_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  nhp_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output nhp_pkg::rsp_type rsp_item
);

   logic [nhp_pkg::POSITION_BITS-1:0] pos_ff, pos_in;
   logic [1:0]  flags_ff, flags_in;
   logic [7:0]  seq_ff, seq_in;
   logic [15:0] dest_ff, dest_in;
   logic [15:0] src_ff, src_in;
   logic [7:0]  radius_ff, radius_in;
   logic        ext_ff, ext_in;
   logic [7:0]  hop_total_ff, hop_total_in;
   logic [7:0]  hops_seen_ff, hops_seen_in;
   logic [7:0]  hop_low_ff, hop_low_in;

   logic                     req_acc;
   logic                     hop_hit;
   logic [nhp_pkg::LEN_W-1:0] frame_len;
   logic [nhp_pkg::LEN_W-1:0] need_len;
   logic                     ext_end;
   logic                     end_ok;
   nhp_pkg::entry_type       new_entry;

   nhp_pkg::entry_type        ent_ff [nhp_pkg::FIFO_DEPTH];
   logic [nhp_pkg::PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [nhp_pkg::PTR_W:0]   cnt_ff, cnt_in;
   logic                      sub_ff;
   nhp_pkg::entry_type        head;
   logic                      push, pop, rsp_acc, head_last;

   assign req_acc = req_valid && !req_stall;

   // Field capture and frame bookkeeping
   always_comb begin
      pos_in       = pos_ff;
      flags_in     = flags_ff;
      seq_in       = seq_ff;
      dest_in      = dest_ff;
      src_in       = src_ff;
      radius_in    = radius_ff;
      ext_in       = ext_ff;
      hop_total_in = hop_total_ff;
      hops_seen_in = hops_seen_ff;
      hop_low_in   = hop_low_ff;
      hop_hit      = 1'b0;

      case (pos_ff)
         nhp_pkg::POS_FC: begin
            flags_in = {req_item.data_byte[nhp_pkg::FC_ROUTE_BIT],
                        req_item.data_byte[nhp_pkg::FC_SECURITY_BIT]};
         end
         nhp_pkg::POS_SEQ:    seq_in          = req_item.data_byte;
         nhp_pkg::POS_DST_LO: dest_in[7:0]    = req_item.data_byte;
         nhp_pkg::POS_DST_HI: dest_in[15:8]   = req_item.data_byte;
         nhp_pkg::POS_SRC_LO: src_in[7:0]     = req_item.data_byte;
         nhp_pkg::POS_SRC_HI: src_in[15:8]    = req_item.data_byte;
         nhp_pkg::POS_RADIUS: radius_in       = req_item.data_byte;
         nhp_pkg::POS_MARKER: begin
            ext_in = flags_ff[1] && (req_item.data_byte == nhp_pkg::ROUTE_MARKER);
         end
         nhp_pkg::POS_COUNT: begin
            if (ext_ff) begin
               hop_total_in = req_item.data_byte;
            end
         end
         default: begin
            // hop list: low byte on odd positions, high byte completes the hop
            if (ext_ff && (hops_seen_ff < hop_total_ff)) begin
               if (pos_ff[0]) begin
                  hop_low_in = req_item.data_byte;
               end else begin
                  hop_hit      = 1'b1;
                  hops_seen_in = hops_seen_ff + 8'd1;
               end
            end
         end
      endcase

      if (pos_ff != nhp_pkg::POS_MAX) begin
         pos_in = pos_ff + nhp_pkg::POSITION_BITS'(1);
      end

      // frame end status, from the values including this byte
      frame_len = {1'b0, pos_ff} + nhp_pkg::LEN_W'(1);
      ext_end   = ext_ff && (frame_len >= nhp_pkg::EXT_HDR_BASE);
      need_len  = ext_end ? (nhp_pkg::EXT_HDR_BASE + nhp_pkg::LEN_W'({hop_total_in, 1'b0}))
                          : nhp_pkg::BASE_HDR_LEN;
      end_ok    = (frame_len >= nhp_pkg::BASE_HDR_LEN) && (frame_len >= need_len);

      new_entry                     = '0;
      new_entry.hop_vld             = hop_hit;
      new_entry.end_vld             = req_item.end_of_frame;
      new_entry.hop_rsp.kind        = nhp_pkg::KIND_HOP;
      new_entry.hop_rsp.hop_address = {req_item.data_byte, hop_low_ff};
      new_entry.hop_rsp.last_result = !req_item.end_of_frame;
      new_entry.end_rsp.kind        = nhp_pkg::KIND_END;
      new_entry.end_rsp.last_result = 1'b1;
      if (end_ok) begin
         new_entry.end_rsp.ok            = 1'b1;
         new_entry.end_rsp.security      = flags_in[0];
         new_entry.end_rsp.source_route  = flags_in[1];
         new_entry.end_rsp.sequence_res  = seq_in;
         new_entry.end_rsp.destination   = dest_in;
         new_entry.end_rsp.source        = src_in;
         new_entry.end_rsp.radius        = radius_in;
         new_entry.end_rsp.header_length = need_len[9:0];
         new_entry.end_rsp.route_count   = ext_end ? hop_total_in : 8'd0;
      end

      if (req_item.end_of_frame) begin
         pos_in       = '0;
         flags_in     = '0;
         seq_in       = '0;
         dest_in      = '0;
         src_in       = '0;
         radius_in    = '0;
         ext_in       = 1'b0;
         hop_total_in = '0;
         hops_seen_in = '0;
         hop_low_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         flags_ff     <= '0;
         seq_ff       <= '0;
         dest_ff      <= '0;
         src_ff       <= '0;
         radius_ff    <= '0;
         ext_ff       <= 1'b0;
         hop_total_ff <= '0;
         hops_seen_ff <= '0;
         hop_low_ff   <= '0;
      end else if (req_acc) begin
         pos_ff       <= pos_in;
         flags_ff     <= flags_in;
         seq_ff       <= seq_in;
         dest_ff      <= dest_in;
         src_ff       <= src_in;
         radius_ff    <= radius_in;
         ext_ff       <= ext_in;
         hop_total_ff <= hop_total_in;
         hops_seen_ff <= hops_seen_in;
         hop_low_ff   <= hop_low_in;
      end
   end

   // Result queue; sub_ff marks that the head's hop has gone and its frame end is next
   assign head      = ent_ff[rd_ptr_ff];
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_item  = (head.hop_vld && !sub_ff) ? head.hop_rsp : head.end_rsp;
   assign head_last = !(head.hop_vld && head.end_vld && !sub_ff);
   assign rsp_acc   = rsp_valid && !rsp_stall;
   assign pop       = rsp_acc && head_last;
   assign req_stall = (cnt_ff == (nhp_pkg::PTR_W+1)'(nhp_pkg::FIFO_DEPTH)) && !pop;
   assign push      = req_acc && (hop_hit || req_item.end_of_frame);

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + (nhp_pkg::PTR_W+1)'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - (nhp_pkg::PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         sub_ff    <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + nhp_pkg::PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + nhp_pkg::PTR_W'(1);
            sub_ff    <= 1'b0;
         end else if (rsp_acc) begin
            sub_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= new_entry;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (nhp_pkg::PTR_W+1)'(nhp_pkg::FIFO_DEPTH))
      else $error("result queue overfilled");

   a_sub_pair: assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> (rsp_valid && head.hop_vld && head.end_vld))
      else $error("second half pending on an entry without a pair");

   a_hop_ext: assert property (@(posedge clock) disable iff (reset)
      (req_acc && hop_hit) |-> (ext_ff && !pos_ff[0]))
      else $error("hop completed outside the route extension");

   a_eof_clear: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_item.end_of_frame) |=> (pos_ff == '0 && !ext_ff))
      else $error("frame state not cleared after frame end");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_item.kind == nhp_pkg::KIND_END) |-> rsp_item.last_result)
      else $error("frame end transfer not marked last");

endmodule
